// ----- sv/mcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants of the Monte Carlo call option pricer.
// ----------------------------------------------------------------------------
package mcp_pkg;

    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               last_path;
    } t_req;

    typedef struct packed {
        logic [31:0] option_price;
        logic [31:0] path_count;
        logic        sum_saturated;
    } t_res;

    typedef struct packed {
        logic [31:0] payoff;
        logic        last_path;
    } t_item;

    typedef enum logic [1:0] {
        REG_DRIFT    = 2'd0,
        REG_VOL      = 2'd1,
        REG_DISCOUNT = 2'd2,
        REG_STRIKE   = 2'd3
    } t_reg_idx;

    localparam logic [31:0] DRIFT_RESET    = 32'd6619463;
    localparam logic [15:0] VOL_RESET      = 16'd819;
    localparam logic [16:0] DISCOUNT_RESET = 17'd61719;
    localparam logic [15:0] STRIKE_RESET   = 16'd110;

    localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [31:0] ONE_Q30      = 32'd1073741824;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
    localparam int          FIFO_DEPTH   = 4;

    // floor(2^31 / k) for k in 1..12
    function automatic logic [31:0] recip_q31(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd2147483648;
            4'd2:    r = 32'd1073741824;
            4'd3:    r = 32'd715827882;
            4'd4:    r = 32'd536870912;
            4'd5:    r = 32'd429496729;
            4'd6:    r = 32'd357913941;
            4'd7:    r = 32'd306783378;
            4'd8:    r = 32'd268435456;
            4'd9:    r = 32'd238609294;
            4'd10:   r = 32'd214748364;
            4'd11:   r = 32'd195225786;
            4'd12:   r = 32'd178956970;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/monte_carlo_call_option_pricer.sv -----
// ----------------------------------------------------------------------------
// monte_carlo_call_option_pricer
// Black-Scholes Monte Carlo pricer for a European call option.
//
// Requests carry one standard normal sample (signed Q3.12) and a last-path
// mark, over a valid/ready channel. Each request yields a call payoff that
// is added to a saturating sum; the request marked last produces one result
// (discounted mean price, path count, saturation flag) on the output
// valid/ready channel, and the batch state is cleared.
// The front end takes a new request only once it has pushed the last
// payoff; the exponential is a 12-term Taylor series, each term computed
// by multiply, reciprocal multiply and correct. A four-entry queue
// decouples it from the accumulator. The result of a last request passes
// the front end, queue, accumulator, restoring divider and output register.
// A stalled receiver holds the result register; the queue then fills and
// the input stops accepting. Synchronous reset clears the batch, the queue
// and the configuration registers to their defaults.
// Configuration writes are single-cycle, index 0..3, no read-back.
// ----------------------------------------------------------------------------
module monte_carlo_call_option_pricer #(
    parameter int ACC_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mcp_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output mcp_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import mcp_pkg::*;

    logic [31:0] r_drift;
    logic [15:0] r_vol;
    logic [16:0] r_discount;
    logic [15:0] r_strike;

    logic  w_push;
    logic  w_full;
    logic  w_fvalid;
    logic  w_pop;
    t_item w_in_item;
    t_item w_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift    <= DRIFT_RESET;
            r_vol      <= VOL_RESET;
            r_discount <= DISCOUNT_RESET;
            r_strike   <= STRIKE_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DRIFT:    r_drift    <= i_cfg_data;
                REG_VOL:      r_vol      <= i_cfg_data[15:0];
                REG_DISCOUNT: r_discount <= i_cfg_data[16:0];
                REG_STRIKE:   r_strike   <= i_cfg_data[15:0];
                default:      r_drift    <= r_drift;
            endcase
        end
    end

    mcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_req    (i_req),
        .i_drift  (r_drift),
        .i_vol    (r_vol),
        .i_strike (r_strike),
        .o_push   (w_push),
        .o_item   (w_in_item),
        .i_full   (w_full)
    );

    mcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_fvalid),
        .i_pop   (w_pop),
        .o_item  (w_out_item)
    );

    mcp_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_fvalid),
        .o_pop      (w_pop),
        .i_item     (w_out_item),
        .i_discount (r_discount),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (o_res)
    );

endmodule

// ----- sv/mcp_front.sv -----
// ----------------------------------------------------------------------------
// mcp_front
// Takes one sample at a time, evaluates the terminal price with an iterated
// exponential and pushes the payoff into the queue.
// ----------------------------------------------------------------------------
module mcp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mcp_pkg::t_req i_req,
    input  logic [31:0]   i_drift,
    input  logic [15:0]   i_vol,
    input  logic [15:0]   i_strike,
    output logic          o_push,
    output mcp_pkg::t_item o_item,
    input  logic          i_full
);
    import mcp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_X, S_Y, S_T, S_MUL, S_REC, S_COR, S_PROD, S_PRICE, S_PUSH
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_z;
    logic               r_last;
    logic signed [32:0] r_x;
    logic signed [33:0] r_y;
    logic [29:0]        r_t;
    logic [30:0]        r_term;
    logic [30:0]        r_v;
    logic [30:0]        r_q;
    logic [31:0]        r_acc;
    logic [3:0]         r_k;
    logic [63:0]        r_prod;
    t_item              r_item;

    logic signed [32:0] w_x;
    logic signed [63:0] w_xy;
    logic [59:0]        w_t;
    logic [60:0]        w_tv;
    logic [62:0]        w_rq;
    logic [34:0]        w_qk;
    logic [30:0]        w_rem;
    logic [30:0]        w_qc;
    logic signed [9:0]  w_n;
    logic signed [10:0] w_s;
    logic [5:0]         w_ls;
    logic [63:0]        w_rsh;
    logic [31:0]        w_price;
    logic [31:0]        w_strike;

    assign w_x  = $signed({1'b0, i_vol}) * r_z;
    assign w_xy = 64'(r_x) * $signed({33'd0, LOG2E_Q30});
    assign w_t  = {r_y[23:0], 6'd0} * LN2_Q30;
    assign w_tv = r_term * r_t;
    assign w_rq = r_v * recip_q31(r_k);
    assign w_qk = r_q * r_k;
    assign w_rem = r_v - w_qk[30:0];
    assign w_qc = (w_rem >= 31'(r_k)) ? r_q + 31'd1 : r_q;

    assign w_n   = r_y[33:24];
    assign w_s   = 11'sd30 - 11'(w_n);
    assign w_ls  = w_s[5:0];
    assign w_rsh = r_prod >> w_ls;
    assign w_strike = {i_strike, 16'd0};

    always_comb begin
        logic [5:0] nls;
        nls = 6'(-w_s);
        if (w_s >= 11'sd64) begin
            w_price = 32'd0;
        end else if (w_s >= 11'sd0) begin
            w_price = (w_rsh > 64'(MAX32)) ? MAX32 : w_rsh[31:0];
        end else if (r_prod == 64'd0) begin
            w_price = 32'd0;
        end else if (w_s <= -11'sd32 || r_prod > 64'(MAX32 >> nls)) begin
            w_price = MAX32;
        end else begin
            w_price = r_prod[31:0] << nls;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_z     <= i_req.normal_sample;
                        r_last  <= i_req.last_path;
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    r_x     <= w_x;
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= w_xy[63:30];
                    r_state <= S_T;
                end
                S_T: begin
                    r_t     <= w_t[59:30];
                    r_term  <= ONE_Q30[30:0];
                    r_acc   <= ONE_Q30;
                    r_k     <= 4'd1;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_v     <= w_tv[60:30];
                    r_state <= S_REC;
                end
                S_REC: begin
                    r_q     <= w_rq[61:31];
                    r_state <= S_COR;
                end
                S_COR: begin
                    r_term <= w_qc;
                    r_acc  <= r_acc + 32'(w_qc);
                    r_k    <= r_k + 4'd1;
                    if (r_k == TAYLOR_TERMS) begin
                        r_state <= S_PROD;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_PROD: begin
                    r_prod  <= i_drift * r_acc;
                    r_state <= S_PRICE;
                end
                S_PRICE: begin
                    r_item.payoff    <= (w_price > w_strike) ? w_price - w_strike : 32'd0;
                    r_item.last_path <= r_last;
                    r_state          <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/mcp_fifo.sv -----
// ----------------------------------------------------------------------------
// mcp_fifo
// Short queue of payloads between the price front end and the accumulator.
// ----------------------------------------------------------------------------
module mcp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcp_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output mcp_pkg::t_item o_item
);
    import mcp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_item         r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

// ----- sv/mcp_back.sv -----
// ----------------------------------------------------------------------------
// mcp_back
// Accumulates payoffs and, at the end of a batch, divides, discounts and
// presents the price.
// ----------------------------------------------------------------------------
module mcp_back #(
    parameter int ACC_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  mcp_pkg::t_item i_item,
    input  logic [16:0]   i_discount,
    output logic          o_valid,
    input  logic          i_ready,
    output mcp_pkg::t_res o_res
);
    import mcp_pkg::*;

    localparam int CW = $clog2(ACC_WIDTH + 1);

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} t_state;

    t_state               r_state;
    logic [ACC_WIDTH-1:0] r_sum;
    logic [31:0]          r_cnt;
    logic                 r_sat;
    logic [ACC_WIDTH-1:0] r_quo;
    logic [32:0]          r_rem;
    logic [CW-1:0]        r_bits;
    logic                 r_out_valid;
    t_res                 r_out;

    logic [ACC_WIDTH:0]   w_add;
    logic [ACC_WIDTH-1:0] w_sum;
    logic                 w_sat;
    logic [31:0]          w_cnt;
    logic [33:0]          w_trial;
    logic [31:0]          w_mean;
    logic [48:0]          w_scaled;

    assign w_add = {1'b0, r_sum} + (ACC_WIDTH+1)'(i_item.payoff);
    assign w_sum = w_add[ACC_WIDTH] ? '1 : w_add[ACC_WIDTH-1:0];
    assign w_sat = r_sat | w_add[ACC_WIDTH];
    assign w_cnt = (r_cnt == MAX32) ? r_cnt : r_cnt + 32'd1;

    assign w_trial  = {r_rem, r_quo[ACC_WIDTH-1]};
    assign w_mean   = (|r_quo[ACC_WIDTH-1:32]) ? MAX32 : r_quo[31:0];
    assign w_scaled = w_mean * i_discount;

    assign o_pop   = (r_state == B_IDLE) && i_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != B_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_sum <= w_sum;
                        r_cnt <= w_cnt;
                        r_sat <= w_sat;
                        if (i_item.last_path) begin
                            r_quo   <= w_sum;
                            r_rem   <= '0;
                            r_bits  <= CW'(ACC_WIDTH);
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    if (w_trial >= {2'b0, r_cnt}) begin
                        r_rem <= 33'(w_trial - {2'b0, r_cnt});
                        r_quo <= {r_quo[ACC_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[32:0];
                        r_quo <= {r_quo[ACC_WIDTH-2:0], 1'b0};
                    end
                    r_bits <= r_bits - CW'(1);
                    if (r_bits == CW'(1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.option_price  <= (w_scaled[48]) ? MAX32 : w_scaled[47:16];
                        r_out.path_count    <= r_cnt;
                        r_out.sum_saturated <= r_sat;
                        r_out_valid         <= 1'b1;
                        r_sum               <= '0;
                        r_cnt               <= '0;
                        r_sat               <= 1'b0;
                        r_state             <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the Monte Carlo call option pricer.
//
// A queue-fed driver offers sample requests and a monitor checks each
// batch result against a bit-exact fixed-point pricing model kept here.
// Phases sweep the pricing registers, including their extremes, and vary
// sender idling and receiver stalls. One phase holds the receiver off long
// enough for the block to fill up and stop taking requests.
// ----------------------------------------------------------------------------
module tb;
    import mcp_pkg::*;

    localparam int ACC_W = 64;
    localparam logic [63:0] ACC_TOP = {ACC_W{1'b1}};
    localparam int BATCHES_PER_PHASE = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_req        i_req = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    monte_carlo_call_option_pricer #(.ACC_WIDTH(ACC_W)) dut (.*);

    always #2 i_clk = ~i_clk;

    logic [31:0] m_drift = DRIFT_RESET;
    logic [15:0] m_vol = VOL_RESET;
    logic [16:0] m_disc = DISCOUNT_RESET;
    logic [15:0] m_strike = STRIKE_RESET;
    logic [63:0] m_sum = '0;
    logic [31:0] m_paths = '0;
    logic        m_sat = 1'b0;

    t_req pending_reqs[$];
    t_res batch_prices[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;
    int   errors = 0;
    int   results_seen = 0;
    int   batches = 0;
    logic accepted_q = 1'b0;

    function automatic logic [63:0] exp2_frac(input logic [63:0] f24);
        logic [63:0] t, term, acc;
        t = ((f24 << 6) * 64'(LN2_Q30)) >> 30;
        term = 64'(ONE_Q30);
        acc = term;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * t) >> 30) / k;
            acc += term;
        end
        return acc;
    endfunction

    function automatic logic [31:0] terminal_price(input logic signed [15:0] z);
        logic signed [63:0] x, y, n, s;
        logic [63:0] p, prod, price;
        x = $signed({1'b0, m_vol}) * 64'(z);
        y = (x * $signed({1'b0, LOG2E_Q30})) >>> 30;
        n = y >>> 24;
        p = exp2_frac(64'(y[23:0]));
        prod = 64'(m_drift) * p;
        s = 30 - n;
        if (s >= 64) price = 0;
        else if (s >= 0) price = prod >> s;
        else if (prod == 0) price = 0;
        else if (-s >= 32 || prod > (64'(MAX32) >> (-s))) price = 64'(MAX32);
        else price = prod << (-s);
        return (price > 64'(MAX32)) ? MAX32 : price[31:0];
    endfunction

    task automatic price_path(input t_req r);
        logic [63:0] pr, strike, payoff, mean, res;
        t_res e;
        pr = 64'(terminal_price(r.normal_sample));
        strike = 64'(m_strike) << 16;
        payoff = (pr > strike) ? pr - strike : 0;
        if (m_sum > ACC_TOP - payoff) begin
            m_sum = ACC_TOP;
            m_sat = 1'b1;
        end else m_sum += payoff;
        if (m_paths != MAX32) m_paths++;
        if (r.last_path) begin
            mean = m_sum / m_paths;
            if (mean > 64'(MAX32)) mean = 64'(MAX32);
            res = (mean * 64'(m_disc)) >> 16;
            if (res > 64'(MAX32)) res = 64'(MAX32);
            e.option_price = res[31:0];
            e.path_count = m_paths;
            e.sum_saturated = m_sat;
            batch_prices.push_back(e);
            m_sum = '0;
            m_paths = '0;
            m_sat = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) price_path(i_req);
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (batch_prices.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", o_res);
            end else if (o_res !== batch_prices[0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected price %h count %0d sat %b, got %h %0d %b",
                             batch_prices[0].option_price, batch_prices[0].path_count,
                             batch_prices[0].sum_saturated, o_res.option_price,
                             o_res.path_count, o_res.sum_saturated);
                void'(batch_prices.pop_front());
            end else void'(batch_prices.pop_front());
        end
    end

    always @(posedge i_clk) accepted_q <= i_valid && o_ready && i_rst_n;

    // Drive at the falling edge; drop the request accepted at the last rising edge.
    always @(negedge i_clk) begin
        if (accepted_q && pending_reqs.size() > 0) begin
            void'(pending_reqs.pop_front());
        end
        if (i_valid && !accepted_q) begin
            // hold
        end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            i_req <= pending_reqs[0];
        end else i_valid <= 1'b0;
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DRIFT:    m_drift = val;
            REG_VOL:      m_vol = val[15:0];
            REG_DISCOUNT: m_disc = val[16:0];
            REG_STRIKE:   m_strike = val[15:0];
            default: begin
            end
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid) @(posedge i_clk);
        while (batch_prices.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic add_req(input logic signed [15:0] z, input logic last);
        t_req r;
        r.normal_sample = z;
        r.last_path = last;
        pending_reqs.push_back(r);
    endtask

    task automatic random_batches(input int count);
        int len;
        for (int i = 0; i < count; i++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 1);
            for (int j = 0; j < len; j++)
                add_req(($urandom_range(3) == 0) ? 16'($urandom) :
                        16'($signed($urandom_range(16383)) - 8192), j == len - 1);
            batches++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_req(16'sh7FFF, 1'b0);
        add_req(16'sh8000, 1'b1);
        add_req(16'sd0, 1'b1);
        add_req(16'sh7FFF, 1'b0);
        add_req(16'sh7FFF, 1'b0);
        add_req(16'sd4096, 1'b1);
        add_req(-16'sd4096, 1'b1);
        add_req(16'shFFFF, 1'b0);
        add_req(16'sh5555, 1'b0);
        add_req(16'shAAAA, 1'b1);
        drain();

        write_reg(REG_DRIFT, MAX32);
        write_reg(REG_VOL, 32'h0000_FFFF);
        write_reg(REG_DISCOUNT, 32'd65536);
        write_reg(REG_STRIKE, 32'd0);
        for (int i = 0; i < 6; i++) add_req(16'sh7FFF, i == 5);
        add_req(16'sh8000, 1'b1);
        add_req(16'sd1000, 1'b1);
        drain();

        write_reg(REG_DRIFT, 32'd0);
        write_reg(REG_STRIKE, 32'h0000_FFFF);
        write_reg(REG_DISCOUNT, 32'h1FFFF);
        add_req(16'sd100, 1'b1);
        add_req(16'sh7FFF, 1'b1);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_DRIFT, (ph == 1) ? MAX32 : $urandom_range(32'h00FF_FFFF));
            write_reg(REG_VOL, (ph == 2) ? 32'h0000_FFFF : $urandom_range(4095));
            write_reg(REG_DISCOUNT, (ph == 3) ? 32'd0 : $urandom_range(32'h1FFFF));
            write_reg(REG_STRIKE, (ph == 4) ? 32'd0 : $urandom_range(255));
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_cycles = 3000; end
                default: begin end
            endcase
            if (ph == 4)
                for (int k = 0; k < 12; k++) add_req(16'($urandom), 1'b1);
            random_batches(BATCHES_PER_PHASE);
            drain();
        end

        $display("Covered %0d random batches plus directed extremes; %0d results checked.",
                 batches, results_seen);
        if (errors == 0 && batch_prices.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", errors);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
